@@ rtl/delta_rle_encoder_defines.svh @@
// Assertion macros shared by the delta run-length encoder checkers.
// Depends on nothing; expects signals named clk and rst in the using scope.
`ifndef DELTA_RLE_ENCODER_DEFINES_SVH
`define DELTA_RLE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dre_pkg.sv @@
// Shared types, codes and the run flush function of the delta run-length encoder.
// Depends on nothing; used by every module of the block.
package dre_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'hFF;
  localparam logic [7:0] MIN_RUN     = 8'd3;
  localparam int         CFG_IDX_W   = 1;
  localparam int         CFG_DATA_W  = 8;
  localparam int         BUNDLE_SLOTS = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN      = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic       delta_enable;
    logic [7:0] max_run;
  } cfg_t;

  // Up to three code bytes from flushing one run; slot 0 goes out first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } flush_t;

  // All code bytes caused by one input item; slot 0 goes out first.
  typedef struct packed {
    logic [BUNDLE_SLOTS-1:0][7:0] bytes;
    logic [2:0]                   count;
    logic                         last;
  } bundle_t;

  // Code bytes for a run of the given value and length (zero length gives none).
  function automatic flush_t flush_run(input logic [7:0] value, input logic [7:0] len);
    flush_t f;
    f.bytes = '0;
    f.count = 2'd0;
    if (len >= MIN_RUN) begin
      f.bytes[0] = ESC_BYTE;
      f.bytes[1] = value;
      f.bytes[2] = len;
      f.count    = 2'd3;
    end else if (len != 8'd0) begin
      if (value == ESC_BYTE) begin
        // An escape byte, single or paired, always goes out as a triple.
        f.bytes[0] = ESC_BYTE;
        f.bytes[1] = ESC_BYTE;
        f.bytes[2] = len;
        f.count    = 2'd3;
      end else begin
        f.bytes[0] = value;
        f.bytes[1] = value;
        f.count    = len[1:0];
      end
    end
    return f;
  endfunction

endpackage

@@ rtl/dre_encoder.sv @@
// Delta stage and run tracker: turns one accepted item into a bundle of code bytes.
// Depends on dre_pkg.
module dre_encoder (
  input  logic              clk,
  input  logic              rst,
  input  dre_pkg::cfg_t     cfg,
  input  logic              take,
  input  dre_pkg::in_item_t item,
  output dre_pkg::bundle_t  bundle
);
  import dre_pkg::*;

  logic [7:0] prev_raw;
  logic       first_pending;
  logic [7:0] run_value;
  logic [7:0] run_length;

  logic [7:0] run_value_next;
  logic [7:0] run_length_next;
  logic [7:0] limit;
  logic [7:0] d;
  logic       extend;
  logic [7:0] open_value;
  logic [7:0] open_length;
  flush_t     flush_old;
  flush_t     flush_new;

  // Byte delta, bypassed on the first byte of a message or when disabled.
  always_comb begin
    limit = (cfg.max_run < MIN_RUN) ? MIN_RUN : cfg.max_run;
    if (first_pending || !cfg.delta_enable) begin
      d = item.data_byte;
    end else begin
      d = item.data_byte - prev_raw;
    end
  end

  // Run extension or break, and the flush on the last byte.
  always_comb begin
    extend      = (run_length != 8'd0) && (d == run_value) && (run_length < limit);
    flush_old   = extend ? flush_t'('0) : flush_run(run_value, run_length);
    open_value  = extend ? run_value : d;
    open_length = extend ? run_length + 8'd1 : 8'd1;
    flush_new   = item.last_in ? flush_run(open_value, open_length) : flush_t'('0);
    run_value_next  = open_value;
    run_length_next = item.last_in ? 8'd0 : open_length;
  end

  // Pack the old run's bytes first, then the flushed new run.
  always_comb begin
    bundle.bytes = '0;
    bundle.count = {1'b0, flush_old.count} + {1'b0, flush_new.count};
    bundle.last  = item.last_in;
    case (flush_old.count)
      2'd0: begin
        bundle.bytes[2:0] = flush_new.bytes;
      end
      2'd1: begin
        bundle.bytes[0]   = flush_old.bytes[0];
        bundle.bytes[3:1] = flush_new.bytes;
      end
      2'd2: begin
        bundle.bytes[1:0] = flush_old.bytes[1:0];
        bundle.bytes[4:2] = flush_new.bytes;
      end
      default: begin
        bundle.bytes[2:0] = flush_old.bytes;
        bundle.bytes[5:3] = flush_new.bytes;
      end
    endcase
  end

  // Message state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw      <= 8'd0;
      first_pending <= 1'b1;
      run_value     <= 8'd0;
      run_length    <= 8'd0;
    end else if (take) begin
      prev_raw      <= item.data_byte;
      first_pending <= item.last_in;
      run_value     <= run_value_next;
      run_length    <= run_length_next;
    end
  end

endmodule

@@ rtl/dre_serializer.sv @@
// Output register bank that sends a bundle of code bytes one byte per transfer.
// Depends on dre_pkg.
module dre_serializer (
  input  logic               clk,
  input  logic               rst,
  input  dre_pkg::bundle_t   bundle,
  input  logic               load,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output dre_pkg::out_item_t out_data
);
  import dre_pkg::*;

  logic [BUNDLE_SLOTS-1:0][7:0] bytes;
  logic [2:0]                   rem;
  logic                         last;

  // A new bundle fits once the bank is empty or its final byte leaves now.
  always_comb begin
    can_load           = (rem == 3'd0) || ((rem == 3'd1) && !out_stall);
    out_valid          = (rem != 3'd0);
    out_data.code_byte = bytes[0];
    out_data.last_out  = last && (rem == 3'd1);
  end

  // Bytes shift toward slot 0 on each output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= bundle.count;
    end else if (out_valid && !out_stall) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= bundle.bytes;
      last  <= bundle.last;
    end else if (out_valid && !out_stall) begin
      bytes <= {8'd0, bytes[BUNDLE_SLOTS-1:1]};
    end
  end

endmodule

@@ rtl/delta_rle_encoder.sv @@
// Latency: the first code byte of an item is shown the cycle after its input transfer.
// Throughput: one item per cycle while each item yields at most one code byte and the
// output does not stall; an item with more (up to six) stalls input until its last byte
// leaves, paced by the output byte register. Reset (synchronous, active high) empties
// the output bank, starts a new message and sets delta_enable to 1 and max_run to 255.
module delta_rle_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dre_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dre_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dre_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dre_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    can_load;
  logic    take;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delta_enable <= 1'b1;
      cfg.max_run      <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DELTA_ENABLE: cfg.delta_enable <= cfg_data[0];
        CFG_MAX_RUN:      cfg.max_run      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // An input transfer loads its bundle into the output bank in the same edge.
  assign in_stall = !can_load;
  assign take     = in_valid && can_load;

  dre_encoder u_enc (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .take   (take),
    .item   (in_data),
    .bundle (bundle)
  );

  dre_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .load      (take),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/dre_checker.sv @@
// Port-level checks for the delta run-length encoder, bound to its top level.
// Depends on dre_pkg and delta_rle_encoder_defines.svh.
`include "delta_rle_encoder_defines.svh"

module dre_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input dre_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dre_pkg::out_item_t out_data
);
  import dre_pkg::*;

  logic in_xfer;
  logic out_xfer;
  logic out_held;
  logic end_xfer;

  // Transfer conditions seen at the ports.
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_held = out_valid && out_stall;
  assign end_xfer = out_xfer && out_data.last_out;

  // A stalled result holds until its transfer.
  `DRE_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "held output changed")

  // With nothing pending and no input transfer, no result appears.
  `DRE_ASSERT_NEXT(a_no_invent, !out_valid && !in_xfer, !out_valid, "output without input")

  // The input only stalls behind pending code bytes.
  `DRE_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with empty output")

  // Once the final byte of a message leaves with no new input, the output is empty.
  `DRE_ASSERT_NEXT(a_last_single, end_xfer && !in_xfer, !out_valid, "bytes after message end")

endmodule

bind delta_rle_encoder dre_checker u_chk (.*);
